// ===== rtl/core/msx_pkg.sv =====
// Package for the MIPS subset execute unit: operation codes, widths and the
// shared request structs. Depends on nothing.
package msx_pkg;

   localparam int PC_BITS    = 10;
   localparam int MEM_BYTES  = 512;
   localparam int MEM_ABITS  = $clog2(MEM_BYTES);
   localparam int REG_COUNT  = 32;
   localparam int REG_ABITS  = 5;
   localparam int WORD_BITS  = 32;

   typedef enum logic [4:0] {
      MODE_NOP  = 5'd0,  MODE_LW   = 5'd1,  MODE_LI   = 5'd2,  MODE_LA   = 5'd3,
      MODE_SW   = 5'd4,  MODE_MOVE = 5'd5,  MODE_MFHI = 5'd6,  MODE_MFLO = 5'd7,
      MODE_ADD  = 5'd8,  MODE_ADDU = 5'd9,  MODE_SUB  = 5'd10, MODE_SUBU = 5'd11,
      MODE_MULT = 5'd12, MODE_DIV  = 5'd13, MODE_AND  = 5'd14, MODE_NOR  = 5'd15,
      MODE_NOT  = 5'd16, MODE_OR   = 5'd17, MODE_XOR  = 5'd18, MODE_J    = 5'd19,
      MODE_BEQ  = 5'd20, MODE_BNE  = 5'd21, MODE_BLT  = 5'd22, MODE_BLE  = 5'd23,
      MODE_BGT  = 5'd24, MODE_BGE  = 5'd25
   } mode_type;

   // Register file write request.
   typedef struct packed {
      logic                 we;
      logic [REG_ABITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
   } rf_write_type;

   // Data memory byte access request.
   typedef struct packed {
      logic                 re;
      logic                 we;
      logic [MEM_ABITS-1:0] addr;
      logic [7:0]           data;
   } dm_access_type;

endpackage

// ===== rtl/core/msx_channels.sv =====
// Handshake interfaces for the request and response channels.
// Depends on msx_pkg for the program counter width.
interface msx_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  mode;
   logic [4:0]  dest_reg;
   logic [4:0]  first_reg;
   logic [4:0]  second_reg;
   logic        use_register;
   logic signed [31:0] immediate;
   logic [msx_pkg::PC_BITS-1:0] target;
   modport source (output valid, mode, dest_reg, first_reg, second_reg, use_register,
                   immediate, target, input ready);
   modport sink (input valid, mode, dest_reg, first_reg, second_reg, use_register,
                 immediate, target, output ready);
endinterface

interface msx_rsp_if;
   logic        valid;
   logic        ready;
   logic [msx_pkg::PC_BITS-1:0] next_pc;
   logic        write_enable;
   logic [4:0]  written_reg;
   logic [31:0] write_value;
   logic [31:0] hi_value;
   logic [31:0] lo_value;
   logic        divide_by_zero;
   modport source (output valid, next_pc, write_enable, written_reg, write_value,
                   hi_value, lo_value, divide_by_zero, input ready);
   modport sink (input valid, next_pc, write_enable, written_reg, write_value,
                 hi_value, lo_value, divide_by_zero, output ready);
endinterface

// ===== rtl/core/msx_regfile.sv =====
// General register file: a synchronous memory with one read and one write port.
// Depends on msx_pkg. Valid bits make unwritten entries and register zero read 0.
module msx_regfile (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [msx_pkg::REG_ABITS-1:0] rd_addr,
   output logic [msx_pkg::WORD_BITS-1:0] rd_data,
   input  msx_pkg::rf_write_type         wr_req
);
   logic [msx_pkg::WORD_BITS-1:0] reg_mem [msx_pkg::REG_COUNT];
   logic [msx_pkg::REG_COUNT-1:0] valid_ff;
   logic [msx_pkg::WORD_BITS-1:0] q_ff;
   logic                          hit_ff;

   // Memory array with registered read.
   always_ff @(posedge clock) begin
      if (wr_req.we) begin
         reg_mem[wr_req.addr] <= wr_req.data;
      end
      q_ff <= reg_mem[rd_addr];
   end

   // Valid bits are cleared by reset; register zero is never marked valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_req.we && (wr_req.addr != '0)) begin
            valid_ff[wr_req.addr] <= 1'b1;
         end
         hit_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? q_ff : '0;
endmodule

// ===== rtl/core/msx_datamem.sv =====
// Byte-wide data memory with registered read and a clearing pass after reset.
// Depends on msx_pkg. busy stays high after reset until every byte is cleared.
module msx_datamem (
   input  logic                    clock,
   input  logic                    reset,
   input  msx_pkg::dm_access_type  acc,
   output logic [7:0]              rd_data,
   output logic                    busy
);
   logic [7:0]                  byte_mem [msx_pkg::MEM_BYTES];
   logic [msx_pkg::MEM_ABITS:0] clr_ff;
   logic [msx_pkg::MEM_ABITS:0] clr_in;
   logic                        clearing;

   assign clearing = !clr_ff[msx_pkg::MEM_ABITS];
   assign busy     = clearing;
   assign clr_in   = clr_ff + 1'b1;

   // Clearing counter runs once through every byte after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_in;
      end
   end

   // Memory array: the clearing pass owns the write port while it runs.
   always_ff @(posedge clock) begin
      if (clearing) begin
         byte_mem[clr_ff[msx_pkg::MEM_ABITS-1:0]] <= 8'd0;
      end else if (acc.we) begin
         byte_mem[acc.addr] <= acc.data;
      end
      if (acc.re) begin
         rd_data <= byte_mem[acc.addr];
      end
   end
endmodule

// ===== rtl/core/msx_divider.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on msx_pkg for the word width.
module msx_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msx_pkg::WORD_BITS-1:0] dividend,
   input  logic [msx_pkg::WORD_BITS-1:0] divisor,
   output logic                          done,
   output logic [msx_pkg::WORD_BITS-1:0] quotient,
   output logic [msx_pkg::WORD_BITS-1:0] remainder
);
   localparam int W = msx_pkg::WORD_BITS;
   localparam int CBITS = $clog2(W + 1);

   logic [W-1:0]     rem_ff, quo_ff, dvs_ff;
   logic [CBITS-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [W:0]       trial;

   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   // One shift and trial subtraction per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[W-2:0], quo_ff[W-1]};
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CBITS'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/core/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: sequencer, operand reads, ALU,
// multiplier and result register. Depends on msx_pkg, the channel interfaces,
// msx_regfile, msx_datamem and msx_divider.
//
// Usage: one pre-decoded instruction arrives as a word on req_chan and one
// result word leaves on rsp_chan; both use valid/ready, a word moving at a
// rising edge with both high. Instructions run one at a time: the three
// operands are read in turn from the register file memory (one read port),
// then the instruction executes and commits.
// Path from acceptance to result: ALU, move, jump and branch words pass through
// the operand reads, execute and finish; lw and sw add a memory step (one data
// memory byte per cycle) and div waits on the iterative divider (one bit per
// cycle). The next word is taken in the cycle after a result is registered.
// After reset the data memory is swept to zero, and req_chan.ready stays low
// while the sweep runs. A stalled receiver holds the result in the output
// register; the next word may be accepted and run up to its commit meanwhile.
module mips_subset_execute_unit (
   input  logic           clock,
   input  logic           reset,
   msx_req_if.sink        req_chan,
   msx_rsp_if.source      rsp_chan
);
   localparam int W = msx_pkg::WORD_BITS;
   localparam int PB = msx_pkg::PC_BITS;
   localparam int AB = msx_pkg::MEM_ABITS;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_RDA  = 8'b0000_0010,
      ST_RDB  = 8'b0000_0100,
      ST_RDD  = 8'b0000_1000,
      ST_EXEC = 8'b0001_0000,
      ST_MEM  = 8'b0010_0000,
      ST_DIVW = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type state_ff;

   // Latched instruction word.
   msx_pkg::mode_type mode_ff;
   logic [4:0]  dest_ff, first_ff, second_ff;
   logic        usereg_ff;
   logic [W-1:0] imm_ff;
   logic [PB-1:0] tgt_ff;

   // Operands and working results.
   logic [W-1:0]  a_ff, b_ff, d_ff, val_ff;
   logic [W-1:0]  hi_ff, lo_ff;
   logic [PB-1:0] pc_ff, npc_ff;
   logic          wr_ff, dz_ff;
   logic [AB-1:0] addr_ff;
   logic [2:0]    cnt_ff;

   // Output register.
   logic          rsp_valid_ff;
   logic [PB-1:0] o_npc_ff;
   logic          o_we_ff, o_dz_ff;
   logic [4:0]    o_reg_ff;
   logic [W-1:0]  o_val_ff, o_hi_ff, o_lo_ff;

   logic [4:0]    rf_raddr;
   logic [W-1:0]  rf_rdata;
   msx_pkg::rf_write_type  rf_wr;
   msx_pkg::dm_access_type dm_acc;
   logic [7:0]    dm_rdata;
   logic          dm_busy;

   logic          div_start, div_done;
   logic [W-1:0]  div_q, div_r, div_md, div_mv;

   logic [W-1:0]  d_now, b_sel;
   logic [PB-1:0] seq_pc;
   logic signed [2*W-1:0] product;
   logic          commit;
   logic [1:0]    ld_byte;

   assign req_chan.ready = (state_ff == ST_IDLE) && !dm_busy;
   assign commit = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   msx_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata),
      .wr_req  (rf_wr)
   );

   msx_datamem u_datamem (
      .clock   (clock),
      .reset   (reset),
      .acc     (dm_acc),
      .rd_data (dm_rdata),
      .busy    (dm_busy)
   );

   msx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_md),
      .divisor   (div_mv),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Register file read address follows the operand read sequence.
   always_comb begin
      unique case (state_ff)
         ST_RDA:  rf_raddr = first_ff;
         ST_RDB:  rf_raddr = second_ff;
         default: rf_raddr = dest_ff;
      endcase
   end

   assign rf_wr.we   = commit && wr_ff;
   assign rf_wr.addr = dest_ff;
   assign rf_wr.data = val_ff;

   // Data memory byte accesses during a load or store.
   always_comb begin
      dm_acc.addr = addr_ff + AB'(cnt_ff[1:0]);
      dm_acc.re   = (state_ff == ST_MEM) && (mode_ff == msx_pkg::MODE_LW) && !cnt_ff[2];
      dm_acc.we   = (state_ff == ST_MEM) && (mode_ff == msx_pkg::MODE_SW) && !cnt_ff[2];
      dm_acc.data = d_ff[8*cnt_ff[1:0] +: 8];
   end
   assign ld_byte = cnt_ff[1:0] - 2'd1;

   // Execute-stage operands and products.
   assign d_now   = rf_rdata;
   assign b_sel   = usereg_ff ? b_ff : imm_ff;
   assign seq_pc  = pc_ff + 1'b1;
   assign product = $signed(d_now) * $signed(a_ff);
   assign div_md  = d_now[W-1] ? (~d_now + 1'b1) : d_now;
   assign div_mv  = a_ff[W-1] ? (~a_ff + 1'b1) : a_ff;
   assign div_start = (state_ff == ST_EXEC) && (mode_ff == msx_pkg::MODE_DIV)
                      && (a_ff != '0);

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid && req_chan.ready) begin
                  mode_ff   <= msx_pkg::mode_type'(req_chan.mode);
                  dest_ff   <= req_chan.dest_reg;
                  first_ff  <= req_chan.first_reg;
                  second_ff <= req_chan.second_reg;
                  usereg_ff <= req_chan.use_register;
                  imm_ff    <= req_chan.immediate;
                  tgt_ff    <= req_chan.target;
                  state_ff  <= ST_RDA;
               end
            end
            ST_RDA: state_ff <= ST_RDB;
            ST_RDB: begin
               a_ff     <= rf_rdata;
               state_ff <= ST_RDD;
            end
            ST_RDD: begin
               b_ff     <= rf_rdata;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               d_ff    <= d_now;
               npc_ff  <= seq_pc;
               wr_ff   <= 1'b0;
               val_ff  <= '0;
               dz_ff   <= 1'b0;
               addr_ff <= usereg_ff ? AB'(a_ff + imm_ff) : imm_ff[AB-1:0];
               cnt_ff  <= '0;
               state_ff <= ST_FIN;
               case (mode_ff)
                  msx_pkg::MODE_LW: begin
                     wr_ff    <= 1'b1;
                     state_ff <= ST_MEM;
                  end
                  msx_pkg::MODE_SW: state_ff <= ST_MEM;
                  msx_pkg::MODE_LI, msx_pkg::MODE_LA: begin
                     val_ff <= imm_ff; wr_ff <= 1'b1;
                  end
                  msx_pkg::MODE_MOVE: begin val_ff <= a_ff;  wr_ff <= 1'b1; end
                  msx_pkg::MODE_MFHI: begin val_ff <= hi_ff; wr_ff <= 1'b1; end
                  msx_pkg::MODE_MFLO: begin val_ff <= lo_ff; wr_ff <= 1'b1; end
                  msx_pkg::MODE_ADD, msx_pkg::MODE_ADDU: begin
                     val_ff <= a_ff + b_sel; wr_ff <= 1'b1;
                  end
                  msx_pkg::MODE_SUB, msx_pkg::MODE_SUBU: begin
                     val_ff <= a_ff - b_sel; wr_ff <= 1'b1;
                  end
                  msx_pkg::MODE_MULT: begin
                     hi_ff <= product[2*W-1:W];
                     lo_ff <= product[W-1:0];
                  end
                  msx_pkg::MODE_DIV: begin
                     if (a_ff == '0) begin
                        dz_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_DIVW;
                     end
                  end
                  msx_pkg::MODE_AND: begin val_ff <= a_ff & b_sel;    wr_ff <= 1'b1; end
                  msx_pkg::MODE_NOR: begin val_ff <= ~(a_ff | b_sel); wr_ff <= 1'b1; end
                  msx_pkg::MODE_NOT: begin
                     val_ff <= usereg_ff ? ~a_ff : ~imm_ff; wr_ff <= 1'b1;
                  end
                  msx_pkg::MODE_OR:  begin val_ff <= a_ff | b_sel; wr_ff <= 1'b1; end
                  msx_pkg::MODE_XOR: begin val_ff <= a_ff ^ b_sel; wr_ff <= 1'b1; end
                  msx_pkg::MODE_J:   npc_ff <= tgt_ff;
                  msx_pkg::MODE_BEQ: if (d_now == a_ff) npc_ff <= tgt_ff;
                  msx_pkg::MODE_BNE: if (d_now != a_ff) npc_ff <= tgt_ff;
                  msx_pkg::MODE_BLT:
                     if ($signed(d_now) < $signed(a_ff)) npc_ff <= tgt_ff;
                  msx_pkg::MODE_BLE:
                     if ($signed(d_now) <= $signed(a_ff)) npc_ff <= tgt_ff;
                  msx_pkg::MODE_BGT:
                     if ($signed(d_now) > $signed(a_ff)) npc_ff <= tgt_ff;
                  msx_pkg::MODE_BGE:
                     if ($signed(d_now) >= $signed(a_ff)) npc_ff <= tgt_ff;
                  default: ;
               endcase
            end
            ST_MEM: begin
               // Load bytes come back in the cycle after their read.
               if ((mode_ff == msx_pkg::MODE_LW) && (cnt_ff != '0)) begin
                  val_ff[8*ld_byte +: 8] <= dm_rdata;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff[2]) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_DIVW: begin
               if (div_done) begin
                  lo_ff <= (d_ff[W-1] != a_ff[W-1]) ? (~div_q + 1'b1) : div_q;
                  hi_ff <= d_ff[W-1] ? (~div_r + 1'b1) : div_r;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (commit) begin
                  pc_ff    <= npc_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Output register: loaded at commit, held while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         o_npc_ff <= npc_ff;
         o_we_ff  <= wr_ff && (dest_ff != '0);
         o_reg_ff <= (wr_ff && (dest_ff != '0)) ? dest_ff : '0;
         o_val_ff <= (wr_ff && (dest_ff != '0)) ? val_ff : '0;
         o_hi_ff  <= hi_ff;
         o_lo_ff  <= lo_ff;
         o_dz_ff  <= dz_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.next_pc        = o_npc_ff;
   assign rsp_chan.write_enable   = o_we_ff;
   assign rsp_chan.written_reg    = o_reg_ff;
   assign rsp_chan.write_value    = o_val_ff;
   assign rsp_chan.hi_value       = o_hi_ff;
   assign rsp_chan.lo_value       = o_lo_ff;
   assign rsp_chan.divide_by_zero = o_dz_ff;
endmodule
